[hdl/matrix3_inverse_core_macros.svh]
// ---------------------------------------------------------------------------
// matrix3 inverse core assertion macros
// shared assertion wrappers, empty when synthesised
// ---------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_CORE_MACROS_SVH
`define MATRIX3_INVERSE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define M3I_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m3i assertion failed");
`define M3I_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m3i assertion failed");
`else
`define M3I_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define M3I_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/m3i_pkg.sv]
// ---------------------------------------------------------------------------
// m3i package
// shared types and constants of the 3x3 inverse core
// ---------------------------------------------------------------------------
`default_nettype none
package m3i_pkg;
   // number of matrix elements per beat
   localparam int LANES = 9;

   // control travelling alongside each beat through the pipeline
   typedef struct packed {
      logic valid;
      logic singular;
   } beat_ctl_type;
endpackage
`default_nettype wire

[hdl/m3i_chan_if.sv]
// ---------------------------------------------------------------------------
// m3i channels
// matrix request and inverse response valid/ready channels
// ---------------------------------------------------------------------------
`default_nettype none
interface m3i_req_if #(parameter int ELEM_WIDTH = 32);
   logic valid;
   logic ready;
   logic signed [ELEM_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 output ready);
endinterface

interface m3i_rsp_if #(parameter int ELEM_WIDTH = 32);
   logic valid;
   logic ready;
   logic signed [ELEM_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic singular;
   logic saturated;
   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, saturated, input ready);
   modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                 singular, saturated, output ready);
endinterface
`default_nettype wire

[hdl/m3i_front.sv]
// ---------------------------------------------------------------------------
// m3i front end
// minors, adjugate, determinant and divider operands over seven stages
// ---------------------------------------------------------------------------
`default_nettype none
module m3i_front #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   localparam int EW = ELEM_WIDTH,
   localparam int AW = 2*EW + 1,
   localparam int DW = 3*EW + 3,
   localparam int NT = 2*EW + 2*FRAC_BITS + 3,
   localparam int NW = ((NT > DW) ? NT : DW) + 1,
   localparam int RW = DW + 2,
   localparam int HW = NW - EW,
   localparam int CW = (HW > RW) ? HW : RW
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [m3i_pkg::LANES-1:0][EW-1:0]     in_elem,
   input  logic                                  out_ready,
   output m3i_pkg::beat_ctl_type                 out_ctl,
   output logic [m3i_pkg::LANES-1:0][NW-1:0]     out_num,
   output logic [DW:0]                           out_d2,
   output logic [m3i_pkg::LANES-1:0]             out_neg,
   output logic [m3i_pkg::LANES-1:0]             out_ovf,
   output logic [m3i_pkg::LANES-1:0][RW-1:0]     out_rem
);
   localparam int NS = 7;

   logic [NS:1] v_ff;
   logic [NS+1:1] rdy;

   // stage 1: products of the minors
   logic signed [2*EW-1:0] pa_ff [m3i_pkg::LANES];
   logic signed [2*EW-1:0] pb_ff [m3i_pkg::LANES];
   logic signed [EW-1:0]   r0a_ff [3];
   // stage 2: adjugate
   logic signed [AW-1:0]   adj2_ff [m3i_pkg::LANES];
   logic signed [EW-1:0]   r0b_ff [3];
   // stage 3: determinant partial products
   logic signed [2*EW:0]   pl_ff [3];
   logic signed [2*EW:0]   ph_ff [3];
   logic signed [AW-1:0]   adj3_ff [m3i_pkg::LANES];
   // stage 4: determinant
   logic signed [DW-1:0]   det_ff;
   logic signed [DW-1:0]   det_in;
   logic signed [AW-1:0]   adj4_ff [m3i_pkg::LANES];
   // stage 5: magnitudes and signs
   logic [DW-1:0]          absd_ff;
   logic [AW-1:0]          absa_ff [m3i_pkg::LANES];
   logic [m3i_pkg::LANES-1:0] neg5_ff;
   logic                   sing5_ff;
   // stage 6: rounded numerator and doubled divisor
   logic [NW-1:0]          num6_ff [m3i_pkg::LANES];
   logic [DW:0]            d26_ff;
   logic [m3i_pkg::LANES-1:0] neg6_ff;
   logic                   sing6_ff;
   // stage 7: overflow check and starting remainder
   logic [m3i_pkg::LANES-1:0][NW-1:0] num7_ff;
   logic [DW:0]            d27_ff;
   logic [m3i_pkg::LANES-1:0] neg7_ff;
   logic [m3i_pkg::LANES-1:0] ovf7_ff;
   logic [m3i_pkg::LANES-1:0][RW-1:0] rem7_ff;
   logic                   sing7_ff;

   // ready ripples back from the output, last stage first
   always_comb begin
      rdy[NS+1] = out_ready;
      for (int s = NS; s >= 1; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end
   assign in_ready = rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[1]) v_ff[1] <= in_valid;
         for (int s = 2; s <= NS; s++) begin
            if (rdy[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   genvar k;
   generate
      for (k = 0; k < m3i_pkg::LANES; k++) begin : g_lane
         localparam int RI = k / 3;
         localparam int CI = k % 3;
         localparam int P0 = (CI == 0) ? 1 : 0;
         localparam int P1 = (CI == 2) ? 1 : 2;
         localparam int Q0 = (RI == 0) ? 1 : 0;
         localparam int Q1 = (RI == 2) ? 1 : 2;
         localparam bit ODD = ((RI + CI) % 2) == 1;
         logic signed [2*EW-1:0] pa_in, pb_in;
         assign pa_in = $signed(in_elem[P0*3+Q0]) * $signed(in_elem[P1*3+Q1]);
         assign pb_in = $signed(in_elem[P0*3+Q1]) * $signed(in_elem[P1*3+Q0]);

         always_ff @(posedge clock) begin
            if (rdy[1]) begin
               pa_ff[k] <= pa_in;
               pb_ff[k] <= pb_in;
            end
            if (rdy[2]) begin
               if (ODD) adj2_ff[k] <= AW'(pb_ff[k]) - AW'(pa_ff[k]);
               else     adj2_ff[k] <= AW'(pa_ff[k]) - AW'(pb_ff[k]);
            end
            if (rdy[3]) adj3_ff[k] <= adj2_ff[k];
            if (rdy[4]) adj4_ff[k] <= adj3_ff[k];
            if (rdy[5]) begin
               absa_ff[k] <= adj4_ff[k][AW-1] ? AW'(-adj4_ff[k]) : AW'(adj4_ff[k]);
               neg5_ff[k] <= adj4_ff[k][AW-1] ^ det_ff[DW-1];
            end
            if (rdy[6]) begin
               num6_ff[k] <= (NW'(absa_ff[k]) << (2*FRAC_BITS + 1)) + NW'(absd_ff);
               neg6_ff[k] <= neg5_ff[k];
            end
            if (rdy[7]) begin
               num7_ff[k] <= num6_ff[k];
               neg7_ff[k] <= neg6_ff[k];
               ovf7_ff[k] <= CW'(num6_ff[k][NW-1:EW]) >= CW'(d26_ff);
               rem7_ff[k] <= RW'(num6_ff[k][NW-1:EW]);
            end
         end
      end

      for (k = 0; k < 3; k++) begin : g_row0
         always_ff @(posedge clock) begin
            if (rdy[1]) r0a_ff[k] <= $signed(in_elem[k]);
            if (rdy[2]) r0b_ff[k] <= r0a_ff[k];
            if (rdy[3]) begin
               // split the cofactor so each multiply stays near one word
               pl_ff[k] <= $signed(r0b_ff[k]) * $signed({1'b0, adj2_ff[3*k][EW-1:0]});
               ph_ff[k] <= $signed(r0b_ff[k]) * $signed(adj2_ff[3*k][AW-1:EW]);
            end
         end
      end
   endgenerate

   always_comb begin
      det_in = '0;
      for (int t = 0; t < 3; t++) begin
         det_in = det_in + (DW'(ph_ff[t]) <<< EW) + DW'(pl_ff[t]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) det_ff <= det_in;
      if (rdy[5]) begin
         absd_ff  <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
         sing5_ff <= det_ff == '0;
      end
      if (rdy[6]) begin
         d26_ff   <= {absd_ff, 1'b0};
         sing6_ff <= sing5_ff;
      end
      if (rdy[7]) begin
         d27_ff    <= d26_ff;
         sing7_ff  <= sing6_ff;
      end
   end

   assign out_ctl.valid    = v_ff[NS];
   assign out_ctl.singular = sing7_ff;
   assign out_num = num7_ff;
   assign out_d2  = d27_ff;
   assign out_neg = neg7_ff;
   assign out_ovf = ovf7_ff;
   assign out_rem = rem7_ff;
endmodule
`default_nettype wire

[hdl/m3i_div_cell.sv]
// ---------------------------------------------------------------------------
// m3i divider cell
// one restoring division step for all nine lanes, registered
// ---------------------------------------------------------------------------
`default_nettype none
module m3i_div_cell #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int BIT_POS    = 0,
   localparam int EW = ELEM_WIDTH,
   localparam int DW = 3*EW + 3,
   localparam int NT = 2*EW + 2*FRAC_BITS + 3,
   localparam int NW = ((NT > DW) ? NT : DW) + 1,
   localparam int RW = DW + 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  m3i_pkg::beat_ctl_type             in_ctl,
   output logic                              in_ready,
   input  logic [m3i_pkg::LANES-1:0][NW-1:0] in_num,
   input  logic [DW:0]                       in_d2,
   input  logic [m3i_pkg::LANES-1:0]         in_neg,
   input  logic [m3i_pkg::LANES-1:0]         in_ovf,
   input  logic [m3i_pkg::LANES-1:0][RW-1:0] in_rem,
   input  logic [m3i_pkg::LANES-1:0][EW-1:0] in_quo,
   input  logic                              out_ready,
   output m3i_pkg::beat_ctl_type             out_ctl,
   output logic [m3i_pkg::LANES-1:0][NW-1:0] out_num,
   output logic [DW:0]                       out_d2,
   output logic [m3i_pkg::LANES-1:0]         out_neg,
   output logic [m3i_pkg::LANES-1:0]         out_ovf,
   output logic [m3i_pkg::LANES-1:0][RW-1:0] out_rem,
   output logic [m3i_pkg::LANES-1:0][EW-1:0] out_quo
);
   logic                              v_ff;
   logic                              sing_ff;
   logic [m3i_pkg::LANES-1:0][NW-1:0] num_ff;
   logic [DW:0]                       d2_ff;
   logic [m3i_pkg::LANES-1:0]         neg_ff, ovf_ff;
   logic [m3i_pkg::LANES-1:0][RW-1:0] rem_ff, rem_in;
   logic [m3i_pkg::LANES-1:0][EW-1:0] quo_ff, quo_in;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      for (int k = 0; k < m3i_pkg::LANES; k++) begin
         logic [RW-1:0] sh;
         sh = {in_rem[k][RW-2:0], in_num[k][BIT_POS]};
         if (sh >= RW'(in_d2)) begin
            rem_in[k] = sh - RW'(in_d2);
            quo_in[k] = in_quo[k] | (EW'(1) << BIT_POS);
         end else begin
            rem_in[k] = sh;
            quo_in[k] = in_quo[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         sing_ff <= in_ctl.singular;
         num_ff  <= in_num;
         d2_ff   <= in_d2;
         neg_ff  <= in_neg;
         ovf_ff  <= in_ovf;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   assign out_ctl.valid    = v_ff;
   assign out_ctl.singular = sing_ff;
   assign out_num = num_ff;
   assign out_d2  = d2_ff;
   assign out_neg = neg_ff;
   assign out_ovf = ovf_ff;
   assign out_rem = rem_ff;
   assign out_quo = quo_ff;
endmodule
`default_nettype wire

[hdl/m3i_out.sv]
// ---------------------------------------------------------------------------
// m3i output stage
// sign, clamp and singular handling into the response register
// ---------------------------------------------------------------------------
`default_nettype none
module m3i_out #(
   parameter int ELEM_WIDTH = 32,
   localparam int EW = ELEM_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  m3i_pkg::beat_ctl_type             in_ctl,
   output logic                              in_ready,
   input  logic [m3i_pkg::LANES-1:0]         in_neg,
   input  logic [m3i_pkg::LANES-1:0]         in_ovf,
   input  logic [m3i_pkg::LANES-1:0][EW-1:0] in_quo,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic [m3i_pkg::LANES-1:0][EW-1:0] out_elem,
   output logic                              out_singular,
   output logic                              out_saturated
);
   localparam logic [EW-1:0] HALF = EW'(1) << (EW - 1);

   logic                              v_ff;
   logic [m3i_pkg::LANES-1:0][EW-1:0] elem_ff, elem_in;
   logic                              sing_ff, sat_ff, sat_in;
   logic [m3i_pkg::LANES-1:0]         big;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      for (int k = 0; k < m3i_pkg::LANES; k++) begin
         big[k] = in_ovf[k] || (in_neg[k] ? (in_quo[k] > HALF) : (in_quo[k] > HALF - 1'b1));
         if (in_ctl.singular) elem_in[k] = '0;
         else if (big[k])     elem_in[k] = in_neg[k] ? HALF : ~HALF;
         else                 elem_in[k] = in_neg[k] ? EW'(-in_quo[k]) : in_quo[k];
      end
      sat_in = !in_ctl.singular && (|big);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         elem_ff <= elem_in;
         sing_ff <= in_ctl.singular;
         sat_ff  <= sat_in;
      end
   end

   assign out_valid     = v_ff;
   assign out_elem      = elem_ff;
   assign out_singular  = sing_ff;
   assign out_saturated = sat_ff;
endmodule
`default_nettype wire

[hdl/matrix3_inverse_core.sv]
// ---------------------------------------------------------------------------
// matrix3 inverse core
// pipelined 3x3 fixed-point matrix inverse by adjugate over determinant
// ---------------------------------------------------------------------------
// usage
//  - req_if carries one 3x3 matrix per beat, signed elements with FRAC_BITS
//    fraction bits; rsp_if returns one inverse per beat in the same format
//  - rsp_if.singular marks a zero determinant, all elements then zero
//  - rsp_if.saturated marks a beat where any element was clamped
//  - pipeline: seven front stages for minors, determinant and operands, one
//    divider cell per quotient bit, and the response register
//  - throughput one beat per cycle while rsp_if is not stalled; the chain of divider cells sets this
//  - each stage moves when it is empty or its successor moves, so bubbles
//    close up and a new beat is taken while a finished one waits on rsp_if
//  - a stalled receiver backs the chain up stage by stage, holding all data
//  - synchronous reset empties every stage; no beat is lost or invented
// ---------------------------------------------------------------------------
`default_nettype none
`include "matrix3_inverse_core_macros.svh"
module matrix3_inverse_core #(
   parameter int FRAC_BITS  = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   m3i_req_if.sink   req_if,
   m3i_rsp_if.source rsp_if
);
   localparam int EW = ELEM_WIDTH;
   localparam int DW = 3*EW + 3;
   localparam int NT = 2*EW + 2*FRAC_BITS + 3;
   localparam int NW = ((NT > DW) ? NT : DW) + 1;
   localparam int RW = DW + 2;

   // matrix elements in row-major order
   logic [m3i_pkg::LANES-1:0][EW-1:0] req_elem;
   logic [m3i_pkg::LANES-1:0][EW-1:0] rsp_elem;

   // divider chain taps, index c feeds cell c
   m3i_pkg::beat_ctl_type             ctl_w [EW+1];
   logic                              rdy_w [EW+1];
   logic [m3i_pkg::LANES-1:0][NW-1:0] num_w [EW+1];
   logic [DW:0]                       d2_w  [EW+1];
   logic [m3i_pkg::LANES-1:0]         neg_w [EW+1];
   logic [m3i_pkg::LANES-1:0]         ovf_w [EW+1];
   logic [m3i_pkg::LANES-1:0][RW-1:0] rem_w [EW+1];
   logic [m3i_pkg::LANES-1:0][EW-1:0] quo_w [EW+1];
   logic                              out_rdy;

   assign req_elem[0] = req_if.m00;
   assign req_elem[1] = req_if.m01;
   assign req_elem[2] = req_if.m02;
   assign req_elem[3] = req_if.m10;
   assign req_elem[4] = req_if.m11;
   assign req_elem[5] = req_if.m12;
   assign req_elem[6] = req_if.m20;
   assign req_elem[7] = req_if.m21;
   assign req_elem[8] = req_if.m22;

   // minors, adjugate, determinant, rounding offset and overflow pre-check
   m3i_front #(.ELEM_WIDTH(EW), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_elem   (req_elem),
      .out_ready (rdy_w[0]),
      .out_ctl   (ctl_w[0]),
      .out_num   (num_w[0]),
      .out_d2    (d2_w[0]),
      .out_neg   (neg_w[0]),
      .out_ovf   (ovf_w[0]),
      .out_rem   (rem_w[0])
   );

   // quotient starts empty, bits fill in from the top down
   assign quo_w[0] = '0;

   genvar c;
   generate
      for (c = 0; c < EW; c++) begin : g_cell
         m3i_div_cell #(
            .ELEM_WIDTH (EW),
            .FRAC_BITS  (FRAC_BITS),
            .BIT_POS    (EW - 1 - c)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_ctl    (ctl_w[c]),
            .in_ready  (rdy_w[c]),
            .in_num    (num_w[c]),
            .in_d2     (d2_w[c]),
            .in_neg    (neg_w[c]),
            .in_ovf    (ovf_w[c]),
            .in_rem    (rem_w[c]),
            .in_quo    (quo_w[c]),
            .out_ready (rdy_w[c+1]),
            .out_ctl   (ctl_w[c+1]),
            .out_num   (num_w[c+1]),
            .out_d2    (d2_w[c+1]),
            .out_neg   (neg_w[c+1]),
            .out_ovf   (ovf_w[c+1]),
            .out_rem   (rem_w[c+1]),
            .out_quo   (quo_w[c+1])
         );
      end
   endgenerate

   // the last cell's remainder and divisor are not needed past here
   assign rdy_w[EW] = out_rdy;

   // sign, clamp and response register
   m3i_out #(.ELEM_WIDTH(EW)) u_out (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (ctl_w[EW]),
      .in_ready      (out_rdy),
      .in_neg        (neg_w[EW]),
      .in_ovf        (ovf_w[EW]),
      .in_quo        (quo_w[EW]),
      .out_ready     (rsp_if.ready),
      .out_valid     (rsp_if.valid),
      .out_elem      (rsp_elem),
      .out_singular  (rsp_if.singular),
      .out_saturated (rsp_if.saturated)
   );

   assign rsp_if.r00 = rsp_elem[0];
   assign rsp_if.r01 = rsp_elem[1];
   assign rsp_if.r02 = rsp_elem[2];
   assign rsp_if.r10 = rsp_elem[3];
   assign rsp_if.r11 = rsp_elem[4];
   assign rsp_if.r12 = rsp_elem[5];
   assign rsp_if.r20 = rsp_elem[6];
   assign rsp_if.r21 = rsp_elem[7];
   assign rsp_if.r22 = rsp_elem[8];

   // singular beats never report clamping
   `M3I_ASSERT_IMPLY(a_sing_no_sat, clock, reset, rsp_if.valid && rsp_if.singular, !rsp_if.saturated)
   // singular beats carry a zero matrix; the diagonal is checked
   `M3I_ASSERT_IMPLY(a_sing_zero, clock, reset, rsp_if.valid && rsp_if.singular, rsp_if.r00 == '0 && rsp_if.r11 == '0 && rsp_if.r22 == '0)
   // a draining receiver frees the whole chain back to the input
   `M3I_ASSERT_IMPLY(a_flow, clock, reset, rsp_if.ready, req_if.ready)
   // response register empties when nothing waits behind it
   `M3I_ASSERT_NEXT(a_drain, clock, reset, rsp_if.valid && rsp_if.ready && !ctl_w[EW].valid, !rsp_if.valid)
endmodule
`default_nettype wire
